>>> hdl/mdo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdo_pkg: shared types, constants and microprogram of the moment observer
// Register map, fixed-point widths, divider constants and the control store
// that sequences the shared multiplier datapath.
// ----------------------------------------------------------------------------
package mdo_pkg;

	// value width cap and default parameter
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VAL_CAP        = 32;

	// field widths
	localparam int RATE_W      = 32;
	localparam int MOM_W       = 32;
	localparam int US_W        = 16;
	localparam int GAIN_W      = 32;
	localparam int INER_W      = 31;
	localparam int IN_TDATA_W  = 3 * RATE_W + 3 * MOM_W + US_W;
	localparam int OUT_TDATA_W = 3 * MOM_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 3'd0,
		REG_J_X    = 3'd1,
		REG_J_Y    = 3'd2,
		REG_J_Z    = 3'd3,
		REG_JINV_X = 3'd4,
		REG_JINV_Y = 3'd5,
		REG_JINV_Z = 3'd6
	} reg_idx_t;

	localparam logic [GAIN_W-1:0] GAIN_RST = 32'hFFF1_0000;  // -15.0 in Q16.16
	localparam logic [INER_W-1:0] J_RST    = 31'd2684355;
	localparam logic [INER_W-1:0] JINV_RST = 31'd6553600;

	// datapath widths
	localparam int OP_W       = 33;           // multiplier operand, signed
	localparam int PROD_W     = 2 * OP_W;     // full product
	localparam int TMP_W      = 48;           // rounded cross-product term
	localparam int A_W        = 43;           // |d*us| + half, below 2^43
	localparam int QE_W       = 24;           // quotient of a / 1e6
	localparam int US_CLAMP_W = 11;           // 500..2000
	localparam int REM_W      = 22;           // remainder below 3e6

	typedef logic signed [PROD_W-1:0] wide_t;

	localparam logic [US_W-1:0] DT_MIN_US = 16'd500;
	localparam logic [US_W-1:0] DT_MAX_US = 16'd2000;

	// a / 1e6 by reciprocal: qe = ((a >> AHI_SHIFT) * DIV_RECIP) >> DIV_SHIFT,
	// qe lands within two of the true quotient, fixed up from the remainder
	localparam int unsigned AHI_SHIFT = 12;
	localparam int unsigned DIV_SHIFT = 39;
	localparam logic [31:0] DIV_RECIP =
		32'((64'd1 << (DIV_SHIFT + AHI_SHIFT)) / 64'd1000000);
	localparam logic [19:0]      MEGA      = 20'd1000000;
	localparam logic [A_W-1:0]   HALF_MEGA = 43'd500000;
	localparam logic [REM_W-1:0] REM_ONE   = 22'd1000000;
	localparam logic [REM_W-1:0] REM_TWO   = 22'd2000000;

	// microcode
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LOOP_START = 5'd13;
	localparam logic [1:0]        AXIS_LAST  = 2'd2;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_KW,      // gain * rate[b]
		MUL_JW,      // inertia[a] * rate[b]
		MUL_WH,      // rate[a] * h[b]
		MUL_JINV_S,  // inv inertia[a] * s
		MUL_KT,      // gain * t
		MUL_DUS,     // d * us
		MUL_RECIP,   // (a >> 12) * reciprocal of 1e6
		MUL_MEGA     // qe * 1e6
	} mul_op_t;

	typedef enum logic [3:0] {
		WB_NONE,
		WB_P,    // p[i]  = sat(rnd16)
		WB_H,    // h[i]  = sat(rnd28)
		WB_C1,   // tmp   = rnd16
		WB_C2,   // c[i]  = sat(tmp - rnd16)
		WB_S,    // s     = sat(z - p - c + m)
		WB_T,    // t     = sat(rnd16)
		WB_D,    // d     = sat(rnd16)
		WB_A,    // a     = |prod| + 5e5, keep sign
		WB_QE,   // qe    = prod >> 39
		WB_Q,    // qmag  = qe + fix-up from remainder
		WB_Z,    // z[i]  = sat(z[i] +- qmag)
		WB_OUT   // result register from z - p
	} wb_op_t;

	// write-back acts on the product issued by the previous step
	typedef struct packed {
		mul_op_t    mul;
		logic [1:0] a_idx;
		logic [1:0] b_idx;
		wb_op_t     wb;
		logic [1:0] wb_idx;
		logic       by_axis;  // indices come from the axis counter
		logic       loop;     // jump to LOOP_START unless on the last axis
		logic       last;
	} ucode_t;

	function automatic ucode_t uc_word(input mul_op_t mul, input logic [1:0] ai,
			input logic [1:0] bi, input wb_op_t wb, input logic [1:0] wi);
		ucode_t cw;
		cw = '{mul, ai, bi, wb, wi, 1'b0, 1'b0, 1'b0};
		return cw;
	endfunction

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
		ucode_t cw;
		cw = uc_word(MUL_NONE, 2'd0, 2'd0, WB_NONE, 2'd0);
		unique case (addr)
			5'd0:  cw = uc_word(MUL_KW,   2'd0, 2'd0, WB_NONE, 2'd0);
			5'd1:  cw = uc_word(MUL_KW,   2'd1, 2'd1, WB_P,    2'd0);
			5'd2:  cw = uc_word(MUL_KW,   2'd2, 2'd2, WB_P,    2'd1);
			5'd3:  cw = uc_word(MUL_JW,   2'd0, 2'd0, WB_P,    2'd2);
			5'd4:  cw = uc_word(MUL_JW,   2'd1, 2'd1, WB_H,    2'd0);
			5'd5:  cw = uc_word(MUL_JW,   2'd2, 2'd2, WB_H,    2'd1);
			// cross product, c2 first since it needs only h0 and h1
			5'd6:  cw = uc_word(MUL_WH,   2'd0, 2'd1, WB_H,    2'd2);
			5'd7:  cw = uc_word(MUL_WH,   2'd1, 2'd0, WB_C1,   2'd0);
			5'd8:  cw = uc_word(MUL_WH,   2'd1, 2'd2, WB_C2,   2'd2);
			5'd9:  cw = uc_word(MUL_WH,   2'd2, 2'd1, WB_C1,   2'd0);
			5'd10: cw = uc_word(MUL_WH,   2'd2, 2'd0, WB_C2,   2'd0);
			5'd11: cw = uc_word(MUL_WH,   2'd0, 2'd2, WB_C1,   2'd0);
			5'd12: cw = uc_word(MUL_NONE, 2'd0, 2'd0, WB_C2,   2'd1);
			// per-axis observer update
			5'd13: begin
				cw = uc_word(MUL_NONE, 2'd0, 2'd0, WB_S, 2'd0);
				cw.by_axis = 1'b1;
			end
			5'd14: begin
				cw = uc_word(MUL_JINV_S, 2'd0, 2'd0, WB_NONE, 2'd0);
				cw.by_axis = 1'b1;
			end
			5'd15: cw = uc_word(MUL_NONE,  2'd0, 2'd0, WB_T,    2'd0);
			5'd16: cw = uc_word(MUL_KT,    2'd0, 2'd0, WB_NONE, 2'd0);
			5'd17: cw = uc_word(MUL_NONE,  2'd0, 2'd0, WB_D,    2'd0);
			5'd18: cw = uc_word(MUL_DUS,   2'd0, 2'd0, WB_NONE, 2'd0);
			5'd19: cw = uc_word(MUL_NONE,  2'd0, 2'd0, WB_A,    2'd0);
			5'd20: cw = uc_word(MUL_RECIP, 2'd0, 2'd0, WB_NONE, 2'd0);
			5'd21: cw = uc_word(MUL_NONE,  2'd0, 2'd0, WB_QE,   2'd0);
			5'd22: cw = uc_word(MUL_MEGA,  2'd0, 2'd0, WB_NONE, 2'd0);
			5'd23: cw = uc_word(MUL_NONE,  2'd0, 2'd0, WB_Q,    2'd0);
			5'd24: begin
				cw = uc_word(MUL_NONE, 2'd0, 2'd0, WB_Z, 2'd0);
				cw.by_axis = 1'b1;
				cw.loop    = 1'b1;
			end
			5'd25: begin
				cw = uc_word(MUL_NONE, 2'd0, 2'd0, WB_OUT, 2'd0);
				cw.last = 1'b1;
			end
			default: cw = uc_word(MUL_NONE, 2'd0, 2'd0, WB_NONE, 2'd0);
		endcase
		return cw;
	endfunction

	// floor((x + 2^(n-1)) / 2^n)
	function automatic wide_t rnd_shift(input wide_t x, input int unsigned n);
		return (x + (wide_t'(1) <<< (n - 1))) >>> n;
	endfunction

endpackage : mdo_pkg
`default_nettype wire

>>> hdl/moment_disturbance_observer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moment_disturbance_observer_unit: rigid-body disturbance moment observer
// Microcoded sequencer around one shared 33x33 multiplier; integrates the
// observer state per tick and returns the disturbance moment estimate.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one tick (body rates, commanded moment, elapsed time); m_*
//   returns one transaction with the three disturbance moments. The cfg_*
//   port writes gain and inertia registers; the user must see that it is
//   used only while idle, since the block itself does not enforce this. The
//   program runs 13 steps for k*w, J*w and the cross product, then 12 steps
//   per axis for the update chain, then one output step. Every step is one
//   control word and at most one pass through the shared multiplier.
//   s_tready rises at the edge that loads the result, so the next tick can
//   be accepted in the cycle after; no new tick is taken while busy.
//   The result sits in an output register; the next tick is accepted while
//   it waits. If it is still not taken when the next result is due, the
//   sequencer holds on its output step until m_tready.
//   Reset clears the observer state, loads the default gain and inertia,
//   and drops m_tvalid.
// ----------------------------------------------------------------------------
module moment_disturbance_observer_unit #(
	parameter int DATA_WIDTH = mdo_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// config
	input  wire logic                           cfg_wr_en,
	input  wire logic [mdo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mdo_pkg::CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// rate_x, rate_y, rate_z, cmd_moment_x, cmd_moment_y, cmd_moment_z, elapsed_us
	input  wire logic [mdo_pkg::IN_TDATA_W-1:0] s_tdata,
	// output stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// dist_moment_x, dist_moment_y, dist_moment_z
	output logic [mdo_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import mdo_pkg::*;

	localparam int VAL_BITS = (DATA_WIDTH < VAL_CAP) ? DATA_WIDTH : VAL_CAP;

	typedef logic signed [VAL_BITS-1:0] val_t;

	localparam wide_t VAL_MAX = {{(PROD_W - VAL_BITS + 1){1'b0}}, {(VAL_BITS - 1){1'b1}}};
	localparam wide_t VAL_MIN = ~VAL_MAX;

	function automatic val_t sat_val(input wide_t x);
		if (x > VAL_MAX) return VAL_MAX[VAL_BITS-1:0];
		if (x < VAL_MIN) return VAL_MIN[VAL_BITS-1:0];
		return x[VAL_BITS-1:0];
	endfunction

	// config registers
	logic signed [GAIN_W-1:0] k_q;
	logic [INER_W-1:0]        j_q    [3];
	logic [INER_W-1:0]        jinv_q [3];

	// sequencer
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        axis_q;
	logic              m_tvalid_q;
	ucode_t            uc;
	logic              in_fire;
	logic              seq_adv;
	logic [1:0]        a_i, b_i, w_i;

	// datapath
	logic signed [RATE_W-1:0] w_q [3];
	logic signed [MOM_W-1:0]  m_q [3];
	logic [US_CLAMP_W-1:0]    us_q;
	val_t                     z_q [3];
	val_t                     p_q [3];
	val_t                     h_q [3];
	val_t                     c_q [3];
	val_t                     dist_q [3];
	val_t                     s_q, t_q, d_q;
	logic signed [TMP_W-1:0]  tmp_q;
	logic                     neg_q;
	logic [A_W-1:0]           a_q;
	logic [QE_W-1:0]          qe_q;
	logic [QE_W-1:0]          qmag_q;
	wide_t                    prod_q;

	logic signed [OP_W-1:0] mul_a, mul_b;
	wide_t                  prod_r16, prod_r28, prod_mag, z_sum;
	logic [A_W:0]           rem_full;
	logic [REM_W-1:0]       rem;
	logic [1:0]             fixup;
	logic [US_W-1:0]        us_in;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = !busy_q;
	assign m_tvalid = m_tvalid_q;

	assign uc      = ucode_rom(step_q);
	assign a_i     = uc.by_axis ? axis_q : uc.a_idx;
	assign b_i     = uc.by_axis ? axis_q : uc.b_idx;
	assign w_i     = uc.by_axis ? axis_q : uc.wb_idx;
	assign seq_adv = !(uc.wb == WB_OUT && m_tvalid_q && !m_tready);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (uc.mul)
			MUL_NONE: ;
			MUL_KW: begin
				mul_a = OP_W'(k_q);
				mul_b = OP_W'(w_q[b_i]);
			end
			MUL_JW: begin
				mul_a = $signed({2'b00, j_q[a_i]});
				mul_b = OP_W'(w_q[b_i]);
			end
			MUL_WH: begin
				mul_a = OP_W'(w_q[a_i]);
				mul_b = OP_W'(h_q[b_i]);
			end
			MUL_JINV_S: begin
				mul_a = $signed({2'b00, jinv_q[a_i]});
				mul_b = OP_W'(s_q);
			end
			MUL_KT: begin
				mul_a = OP_W'(k_q);
				mul_b = OP_W'(t_q);
			end
			MUL_DUS: begin
				mul_a = OP_W'(d_q);
				mul_b = $signed({{(OP_W - US_CLAMP_W){1'b0}}, us_q});
			end
			MUL_RECIP: begin
				mul_a = $signed({2'b00, a_q[A_W-1:AHI_SHIFT]});
				mul_b = $signed({1'b0, DIV_RECIP});
			end
			MUL_MEGA: begin
				mul_a = $signed({{(OP_W - QE_W){1'b0}}, qe_q});
				mul_b = $signed({{(OP_W - 20){1'b0}}, MEGA});
			end
			default: ;
		endcase
	end

	assign prod_r16 = rnd_shift(prod_q, 16);
	assign prod_r28 = rnd_shift(prod_q, 28);
	assign prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;

	// remainder of a - qe*1e6 is below 3e6; add back the lost quotient
	assign rem_full = {1'b0, a_q} - prod_q[A_W:0];
	assign rem      = rem_full[REM_W-1:0];
	always_comb begin
		priority if (rem >= REM_TWO) fixup = 2'd2;
		else if (rem >= REM_ONE)     fixup = 2'd1;
		else                         fixup = 2'd0;
	end

	assign z_sum = neg_q ? wide_t'(z_q[w_i]) - wide_t'($signed({1'b0, qmag_q}))
	                     : wide_t'(z_q[w_i]) + wide_t'($signed({1'b0, qmag_q}));

	assign us_in = s_tdata[IN_TDATA_W-1 -: US_W];

	// control, config and observer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= '0;
			axis_q     <= '0;
			m_tvalid_q <= 1'b0;
			k_q        <= GAIN_RST;
			for (int i = 0; i < 3; i++) begin
				j_q[i]    <= J_RST;
				jinv_q[i] <= JINV_RST;
				z_q[i]    <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_GAIN:   k_q       <= cfg_data[GAIN_W-1:0];
					REG_J_X:    j_q[0]    <= cfg_data[INER_W-1:0];
					REG_J_Y:    j_q[1]    <= cfg_data[INER_W-1:0];
					REG_J_Z:    j_q[2]    <= cfg_data[INER_W-1:0];
					REG_JINV_X: jinv_q[0] <= cfg_data[INER_W-1:0];
					REG_JINV_Y: jinv_q[1] <= cfg_data[INER_W-1:0];
					REG_JINV_Z: jinv_q[2] <= cfg_data[INER_W-1:0];
					default: ;
				endcase
			end
			// a new result wins over the transaction taken at the same edge
			if (busy_q && seq_adv && uc.wb == WB_OUT)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (in_fire) begin
				busy_q <= 1'b1;
				step_q <= '0;
				axis_q <= '0;
			end else if (busy_q && seq_adv) begin
				if (uc.wb == WB_Z)
					z_q[w_i] <= sat_val(z_sum);
				if (uc.last) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else if (uc.loop && axis_q != AXIS_LAST) begin
					step_q <= LOOP_START;
					axis_q <= axis_q + 2'd1;
				end else begin
					step_q <= step_q + STEP_W'(1);
					if (uc.loop)
						axis_q <= '0;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_fire) begin
			for (int i = 0; i < 3; i++) begin
				w_q[i] <= s_tdata[i*RATE_W +: RATE_W];
				m_q[i] <= s_tdata[3*RATE_W + i*MOM_W +: MOM_W];
			end
			priority if (us_in < DT_MIN_US) us_q <= DT_MIN_US[US_CLAMP_W-1:0];
			else if (us_in > DT_MAX_US)     us_q <= DT_MAX_US[US_CLAMP_W-1:0];
			else                            us_q <= us_in[US_CLAMP_W-1:0];
		end else if (busy_q && seq_adv) begin
			unique case (uc.wb)
				WB_NONE: ;
				WB_P:    p_q[w_i] <= sat_val(prod_r16);
				WB_H:    h_q[w_i] <= sat_val(prod_r28);
				WB_C1:   tmp_q    <= prod_r16[TMP_W-1:0];
				WB_C2:   c_q[w_i] <= sat_val(wide_t'(tmp_q) - prod_r16);
				WB_S:    s_q      <= sat_val(wide_t'(z_q[w_i]) - wide_t'(p_q[w_i])
				                             - wide_t'(c_q[w_i]) + wide_t'(m_q[w_i]));
				WB_T:    t_q      <= sat_val(prod_r16);
				WB_D:    d_q      <= sat_val(prod_r16);
				WB_A: begin
					neg_q <= prod_q[PROD_W-1];
					a_q   <= prod_mag[A_W-1:0] + HALF_MEGA;
				end
				WB_QE:   qe_q     <= prod_q[DIV_SHIFT +: QE_W];
				WB_Q:    qmag_q   <= qe_q + QE_W'(fixup);
				WB_Z: ;
				WB_OUT: begin
					for (int i = 0; i < 3; i++)
						dist_q[i] <= sat_val(wide_t'(z_q[i]) - wide_t'(p_q[i]));
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			m_tdata[i*MOM_W +: MOM_W] = MOM_W'(dist_q[i]);
	end

	// checks
	a_done_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> m_tvalid)
		else $error("sequencer finished without presenting a result");

	a_axis_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> axis_q == 2'd0)
		else $error("axis counter left nonzero after the program ended");

	a_hold_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && uc.wb == WB_OUT && m_tvalid && !m_tready |=> busy_q && $stable(step_q))
		else $error("result step advanced while the output register was full");

endmodule : moment_disturbance_observer_unit
`default_nettype wire
